/* sv/cal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cal_pkg;

  localparam int unsigned WIN_AW = 7;   // pixel window of 128 entries
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [1:0] REG_NEAR     = 2'd0;
  localparam logic [1:0] REG_FAR      = 2'd1;
  localparam logic [1:0] REG_ARM      = 2'd2;
  localparam logic [1:0] REG_NEAR_LEN = 2'd3;

  typedef struct packed {
    logic [8:0] near;
    logic [8:0] far;
    logic [6:0] arm_limit;
    logic [6:0] near_len;
  } cfg_t;

  typedef struct packed {
    logic [WIN_AW-1:0] pos;
    logic [6:0]        neg_m;
    logic [6:0]        pos_m;
    logic              line_end;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [23:0]       data;
  } wr_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] color_dist(input logic [23:0] a, input logic [23:0] b);
    logic [7:0] d;
    logic [7:0] e;
    d = abs_diff(a[7:0], b[7:0]);
    e = abs_diff(a[15:8], b[15:8]);
    if (e > d) d = e;
    e = abs_diff(a[23:16], b[23:16]);
    if (e > d) d = e;
    color_dist = d;
  endfunction

endpackage
`default_nettype wire

/* sv/cal_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module cal_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  cal_pkg::job_t      push_data,
  input  wire logic          pop,
  output cal_pkg::job_t      head,
  output logic               full,
  output logic               nonempty
);
  import cal_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/cal_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cal_front #(
  parameter int unsigned MAX_ARM = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  cal_pkg::cfg_t  cfg,
  input  wire logic      accept,
  input  wire logic [23:0] pixel,
  input  wire logic      last,
  input  wire logic      q_full,
  output logic           q_push,
  output cal_pkg::job_t  q_data,
  output cal_pkg::wr_t   wr,
  output logic           idle
);
  import cal_pkg::*;

  typedef enum logic [1:0] {F_IDLE = 2'b01, F_EMIT = 2'b10} fstate_t;

  fstate_t           state_r, state_nxt;
  logic [6:0]        seen_r, seen_nxt;
  logic [6:0]        pend_r, pend_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic              last_r, last_nxt;
  logic [6:0]        lim;
  logic              want;

  always_comb begin
    lim = (cfg.arm_limit > 7'(MAX_ARM)) ? 7'(MAX_ARM) : cfg.arm_limit;
    if (lim == '0) lim = 7'd1;
  end

  assign idle     = (state_r == F_IDLE);
  assign wr.en    = accept;
  assign wr.addr  = wp_r;
  assign wr.data  = pixel;

  assign want = last_r ? (pend_r != '0) : (pend_r >= lim);

  always_comb begin
    q_data.pos      = wp_r - pend_r;
    q_data.neg_m    = (seen_r < lim) ? seen_r : lim;
    q_data.pos_m    = lim;
    if (last_r && ((pend_r - 7'd1) < lim)) q_data.pos_m = pend_r - 7'd1;
    q_data.line_end = last_r && (pend_r == 7'd1);
  end

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    pend_nxt  = pend_r;
    wp_nxt    = wp_r;
    last_nxt  = last_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          wp_nxt    = wp_r + 1'b1;
          if (pend_r != 7'd127) pend_nxt = pend_r + 7'd1;
          last_nxt  = last;
          state_nxt = F_EMIT;
        end
      end
      F_EMIT: begin
        if (want) begin
          if (!q_full) begin
            q_push   = 1'b1;
            pend_nxt = pend_r - 7'd1;
            if (seen_r != 7'd127) seen_nxt = seen_r + 7'd1;
          end
        end else begin
          if (last_r) begin
            pend_nxt = '0;
            seen_nxt = '0;
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    if (!rst_n) begin
      state_r <= F_IDLE;
      seen_r  <= '0;
      pend_r  <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      wp_r    <= wp_nxt;
    end
  end
endmodule
`default_nettype wire

/* sv/cal_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cal_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  cal_pkg::cfg_t  cfg,
  input  cal_pkg::wr_t   wr,
  input  wire logic      q_nonempty,
  input  cal_pkg::job_t  q_head,
  output logic           q_pop,
  output logic           busy,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [5:0]     neg_arm,
  output logic [5:0]     pos_arm,
  output logic           line_end
);
  import cal_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_CEN   = 5'b00010,
    B_ISSUE = 5'b00100,
    B_CHK   = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  logic [23:0]       win [2**WIN_AW];
  logic [23:0]       rd_data_r;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;

  bstate_t     state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [23:0] centre_r, centre_nxt;
  logic [23:0] prev_r, prev_nxt;
  logic [6:0]  k_r, k_nxt;
  logic        fwd_r, fwd_nxt;
  logic [5:0]  neg_r, neg_nxt;
  logic [5:0]  posa_r, posa_nxt;
  logic [6:0]  m;
  logic [6:0]  arm;
  logic [7:0]  dc;
  logic [7:0]  dp;
  logic        ok;
  logic        fin;

  always_ff @(posedge clk) begin
    if (wr.en) win[wr.addr] <= wr.data;
    if (rd_en) rd_data_r <= win[rd_addr];
  end

  assign m  = fwd_r ? job_r.pos_m : job_r.neg_m;
  assign dc = color_dist(centre_r, rd_data_r);
  assign dp = color_dist(rd_data_r, prev_r);
  assign ok = ({1'b0, dc} < cfg.near) && ({1'b0, dp} < cfg.near) &&
              !((k_r > cfg.near_len) && !({1'b0, dc} < cfg.far));

  assign busy      = (state_r != B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign neg_arm   = neg_r;
  assign pos_arm   = posa_r;
  assign line_end  = job_r.line_end;

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    centre_nxt = centre_r;
    prev_nxt   = prev_r;
    k_nxt      = k_r;
    fwd_nxt    = fwd_r;
    neg_nxt    = neg_r;
    posa_nxt   = posa_r;
    rd_en      = 1'b0;
    rd_addr    = fwd_r ? (job_r.pos + k_r[WIN_AW-1:0]) : (job_r.pos - k_r[WIN_AW-1:0]);
    q_pop      = 1'b0;
    fin        = 1'b0;
    arm        = '0;
    case (state_r)
      B_IDLE: begin
        rd_addr = q_head.pos;
        if (q_nonempty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          job_nxt   = q_head;
          state_nxt = B_CEN;
        end
      end
      B_CEN: begin
        centre_nxt = rd_data_r;
        prev_nxt   = rd_data_r;
        k_nxt      = 7'd1;
        fwd_nxt    = 1'b0;
        state_nxt  = B_ISSUE;
      end
      B_ISSUE: begin
        if (k_r >= m) begin
          fin = 1'b1;
          arm = (m == '0) ? 7'd0 : m - 7'd1;
        end else begin
          rd_en     = 1'b1;
          state_nxt = B_CHK;
        end
      end
      B_CHK: begin
        if (!ok) begin
          fin = 1'b1;
          arm = k_r - 7'd1;
        end else begin
          prev_nxt  = rd_data_r;
          k_nxt     = k_r + 7'd1;
          state_nxt = B_ISSUE;
        end
      end
      B_OUT: begin
        if (out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    // one direction done: start the forward walk or present the word
    if (fin) begin
      if (!fwd_r) begin
        neg_nxt   = arm[5:0];
        fwd_nxt   = 1'b1;
        k_nxt     = 7'd1;
        prev_nxt  = centre_r;
        state_nxt = B_ISSUE;
      end else begin
        posa_nxt  = arm[5:0];
        state_nxt = B_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    centre_r <= centre_nxt;
    prev_r   <= prev_nxt;
    k_r      <= k_nxt;
    fwd_r    <= fwd_nxt;
    neg_r    <= neg_nxt;
    posa_r   <= posa_nxt;
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE) && q_nonempty)
    else $error("job taken while busy");
  a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CHK) |-> (k_r >= 7'd1) && (k_r < m))
    else $error("walk step out of range");
  a_arm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, neg_r} <= job_r.neg_m) && ({1'b0, posa_r} <= job_r.pos_m))
    else $error("arm beyond its bound");
endmodule
`default_nettype wire

/* sv/cross_arm_length.sv */
// cross_arm_length: support arm lengths along one line of rgb pixels
//
// in_*   : pixel words, tdata = red, green, blue; tlast marks the final pixel
// out_*  : one word per pixel in line order, tdata = neg_arm, pos_arm;
//          tlast marks the word of the final pixel
// cfg_*  : register writes (0 near limit, 1 far limit, 2 arm limit,
//          3 near length), always ready, to be used while the block is idle
//
// a pixel is taken only when the previous one and all words it released
// are done. the front end stores the pixel in a 128-entry window memory and
// releases jobs into a two-deep queue; the back end walks each job over the
// window memory, one neighbor at a time through its single read port, an
// issue state and then a check state for each. a stalled receiver holds
// the word in the output register and the back end, then the queue, then
// the input side fill and stop in turn. reset clears the counters and the
// control state and sets the config registers to their defaults; the other
// data registers are not cleared and the window memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module cross_arm_length #(
  parameter int unsigned MAX_ARM = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red, green, blue
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // neg_arm, pos_arm, zero pad
  output logic             out_tlast,  // line_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import cal_pkg::*;

  cfg_t  cfg_r;
  job_t  q_data, q_head;
  wr_t   wr;
  logic  q_push, q_pop, q_full, q_nonempty;
  logic  front_idle, back_busy, accept;
  logic [5:0] neg_arm, pos_arm;
  logic  line_end;

  assign cfg_ready = 1'b1;
  assign in_tready = front_idle && !q_nonempty && !back_busy;
  assign accept    = in_tvalid && in_tready;
  assign out_tdata = {4'b0, pos_arm, neg_arm};
  assign out_tlast = line_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near      <= 9'd20;
      cfg_r.far       <= 9'd6;
      cfg_r.arm_limit <= 7'd34;
      cfg_r.near_len  <= 7'd17;
    end else if (cfg_valid && (cfg_index[2] == 1'b0)) begin
      case (cfg_index[1:0])
        REG_NEAR:     cfg_r.near      <= cfg_data;
        REG_FAR:      cfg_r.far       <= cfg_data;
        REG_ARM:      cfg_r.arm_limit <= cfg_data[6:0];
        REG_NEAR_LEN: cfg_r.near_len  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cal_front #(.MAX_ARM(MAX_ARM)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .accept(accept),
    .pixel(in_tdata), .last(in_tlast), .q_full(q_full),
    .q_push(q_push), .q_data(q_data), .wr(wr), .idle(front_idle)
  );

  cal_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data),
    .pop(q_pop), .head(q_head), .full(q_full), .nonempty(q_nonempty)
  );

  cal_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .wr(wr),
    .q_nonempty(q_nonempty), .q_head(q_head), .q_pop(q_pop), .busy(back_busy),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .neg_arm(neg_arm), .pos_arm(pos_arm), .line_end(line_end)
  );
endmodule
`default_nettype wire

/* bench/cal_checker.sv */
`timescale 1ns / 1ps
module cal_checker #(
  parameter int unsigned MAX_ARM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fails,
  output int          words_waiting,
  output int          words_checked
);
  import cal_pkg::*;

  typedef struct packed {
    logic [5:0] neg;
    logic [5:0] pos;
    logic       line_end;
  } arm_word_t;

  arm_word_t   arm_q[$];
  logic [23:0] win[128];
  int unsigned seen, pend, wp;
  int unsigned lim_near, lim_far, arm_reg, near_len;

  function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int unsigned pix_gap(logic [23:0] a, logic [23:0] b);
    int unsigned d;
    int unsigned e;
    d = chan_gap(a[7:0], b[7:0]);
    e = chan_gap(a[15:8], b[15:8]);
    if (e > d) d = e;
    e = chan_gap(a[23:16], b[23:16]);
    if (e > d) d = e;
    return d;
  endfunction

  function automatic int unsigned arm_reach(int unsigned at, bit fwd, int unsigned avail,
                                           int unsigned lim);
    int unsigned m;
    int unsigned dc;
    logic [23:0] ctr, prv, p;
    bit ok;
    m = (avail < lim) ? avail : lim;
    if (m == 0) return 0;
    ctr = win[at & 127];
    prv = ctr;
    for (int unsigned k = 1; k < m; k++) begin
      p = fwd ? win[(at + k) & 127] : win[(at + 128 - k) & 127];
      dc = pix_gap(ctr, p);
      ok = (dc < lim_near) && (pix_gap(p, prv) < lim_near);
      if (k > near_len && !(dc < lim_far)) ok = 0;
      if (!ok) return k - 1;
      prv = p;
    end
    return m - 1;
  endfunction

  task automatic release_word(bit ended, int unsigned lim);
    int unsigned at;
    int unsigned fa;
    arm_word_t w;
    at = (wp + 128 - pend) & 127;
    fa = ended ? pend - 1 : lim;
    w.neg = 6'(arm_reach(at, 0, seen, lim));
    w.pos = 6'(arm_reach(at, 1, fa, lim));
    w.line_end = ended && pend == 1;
    arm_q.push_back(w);
    pend--;
    if (seen < 127) seen++;
  endtask

  task automatic take_pixel(logic [23:0] px, logic last);
    int unsigned lim;
    int n;
    n = 0;
    lim = (arm_reg > MAX_ARM) ? MAX_ARM : arm_reg;
    if (lim < 1) lim = 1;
    win[wp] = px;
    wp = (wp + 1) & 127;
    if (pend < 127) pend++;
    if (last) begin
      while (pend > 0 && n < 64) begin
        release_word(1, lim);
        n++;
      end
      pend = 0;
      seen = 0;
    end else begin
      while (pend >= lim && n < 64) begin
        release_word(0, lim);
        n++;
      end
    end
  endtask

  task automatic note_fail(string what);
    fails++;
    if (fails <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    arm_word_t exp_w;
    arm_word_t got;
    if (!rst_n) begin
      arm_q.delete();
      for (int i = 0; i < 128; i++) win[i] = '0;
      seen = 0;
      pend = 0;
      wp = 0;
      lim_near = 20;
      lim_far = 6;
      arm_reg = 34;
      near_len = 17;
      fails = 0;
      words_checked = 0;
    end else begin
      // output words can only stem from pixels taken at earlier edges
      if (out_tvalid && out_tready) begin
        got.neg = out_tdata[5:0];
        got.pos = out_tdata[11:6];
        got.line_end = out_tlast;
        words_checked++;
        if (arm_q.size() == 0) begin
          note_fail($sformatf("unexpected word neg=%0d pos=%0d end=%0b",
                              got.neg, got.pos, got.line_end));
        end else begin
          exp_w = arm_q.pop_front();
          if (got != exp_w)
            note_fail($sformatf("expected neg=%0d pos=%0d end=%0b, got neg=%0d pos=%0d end=%0b",
                                exp_w.neg, exp_w.pos, exp_w.line_end,
                                got.neg, got.pos, got.line_end));
        end
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          {1'b0, REG_NEAR}:     lim_near = cfg_data;
          {1'b0, REG_FAR}:      lim_far = cfg_data;
          {1'b0, REG_ARM}:      arm_reg = cfg_data[6:0];
          {1'b0, REG_NEAR_LEN}: near_len = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    words_waiting = arm_q.size();
  end
endmodule

/* bench/tb_cross_arm_length.sv */
`timescale 1ns / 1ps
module tb_cross_arm_length;
  import cal_pkg::*;

  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [2:0]  REG_SPARE   = 3'd4;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  int fails, words_waiting, words_checked;
  int send_idle = 0, recv_stall = 0;
  int hold_req = 0, hold_done = 0, hold_left = 0;
  int quiet = 0, pixels_sent = 0, cfg_writes = 0;

  cross_arm_length #(.MAX_ARM(64)) DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cal_checker #(.MAX_ARM(64)) u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .words_waiting, .words_checked
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic set_config(int nr, int fr, int arm, int nl);
    write_reg({1'b0, REG_NEAR}, 9'(nr));
    write_reg({1'b0, REG_FAR}, 9'(fr));
    write_reg({1'b0, REG_ARM}, 9'(arm));
    write_reg({1'b0, REG_NEAR_LEN}, 9'(nl));
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_pixel(logic [23:0] px, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= px;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  task automatic stop_send();
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  // wait until every word is out, plus the tail of a pixel that released none
  task automatic drain();
    stop_send();
    wait (words_waiting == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] drift(logic [7:0] c, int d);
    int v;
    v = int'(c) + $urandom_range(2 * d) - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // a line of mostly smooth colors so arms grow, with some random pixels
  task automatic send_line(int len, int smooth_pct, bit with_end);
    logic [23:0] px;
    int d;
    px = 24'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < smooth_pct) begin
        d = $urandom_range(12);
        px = {drift(px[23:16], d), drift(px[15:8], d), drift(px[7:0], d)};
      end else begin
        px = 24'($urandom);
      end
      send_pixel(px, with_end && i == len - 1);
    end
  endtask

  function automatic int pick_limit();
    case ($urandom_range(5))
      0: return 0;
      1: return 256;
      2: return 1;
      default: return $urandom_range(4, 40);
    endcase
  endfunction

  function automatic int pick_arm();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 80) return 0;
    if (r < 90) return 64;
    return $urandom_range(65, 127);
  endfunction

  task automatic random_config();
    set_config(pick_limit(), pick_limit(), pick_arm(),
               ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8));
  endtask

  initial begin
    int phase_items;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: defaults with extreme colors, single pixel line
    send_pixel(24'h000000, 0);
    send_pixel(24'hffffff, 0);
    send_pixel(24'h000000, 0);
    send_pixel(24'h050505, 0);
    send_pixel(24'h0a0a0a, 1);
    send_pixel(24'h123456, 1);
    drain();
    // zero thresholds: every neighbor fails
    set_config(0, 0, 64, 0);
    write_reg(REG_SPARE, 9'h1ff);
    @(negedge clk);
    cfg_valid <= 0;
    send_line(4, 100, 1);
    drain();
    // arm limit zero, then above the maximum with the widest thresholds
    set_config(256, 256, 0, 127);
    send_line(4, 100, 1);
    drain();
    set_config(256, 256, 127, 0);
    send_line(6, 100, 1);
    drain();
    set_config(511, 511, 2, 64);
    send_line(4, 100, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      phase_items = pixels_sent;
      if (ph == 0) begin
        // lowering the arm limit mid-line releases a whole window at once
        set_config(256, 256, 64, 64);
        send_line(63, 100, 0);
        drain();
        set_config(256, 256, 1, 64);
        send_line(2, 100, 1);
        drain();
      end
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering
        set_config(40, 20, 8, 3);
        hold_req++;
        send_line(30, 90, 1);
        drain();
      end
      if (ph == 2) begin
        // longer line with short arms under receiver stalls
        set_config(30, 10, 3, 1);
        send_line(40, 95, 1);
        drain();
      end
      while (pixels_sent - phase_items < 25) begin
        random_config();
        send_line(($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16),
                  $urandom_range(60, 100), 1);
        drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d pixels and %0d register writes, %0d arm words checked",
             pixels_sent, cfg_writes, words_checked);
    $display("idling phases: none, sender, receiver, both; plus a long receiver hold-off");
    if (fails == 0 && words_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fails, words_waiting);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
